// File: rtl/rwsf_pkg.sv
// Shared types and constants for the rank and weighted strata filter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package rwsf_pkg;

    localparam int DEPTH      = 1024;
    localparam int IDX_W      = 10;
    localparam int CNT_W      = 11;
    localparam int CONS_W     = 16;
    localparam int WGT_W      = 24;
    localparam int TOT_W      = 34;
    localparam int GRP_W      = 4;
    localparam int NG_W       = 5;
    localparam int CUMG_W     = 38;
    localparam int KEY_W      = CONS_W + IDX_W;
    localparam int MAX_GROUPS = 16;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic REG_NUM_GROUPS = 1'b0;
    localparam logic REG_STRATUM    = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_QOUT,
        ST_SCAN,
        ST_PASS_END,
        ST_GRP_WAIT
    } state_t;

    typedef struct packed {
        logic             done;
        logic [GRP_W-1:0] grp;
    } grp_res_t;

    function automatic logic [NG_W-1:0] eff_groups(input logic [NG_W-1:0] ng);
        logic [NG_W-1:0] g;
        if (ng == '0)
            g = NG_W'(1);
        else if (ng > NG_W'(MAX_GROUPS))
            g = NG_W'(MAX_GROUPS);
        else
            g = ng;
        return g;
    endfunction

endpackage

// File: rtl/rwsf_grp_unit.sv
// Iterative group search: finds floor(cum*g/total) clamped to g-1 by
// stepping a threshold one multiple of total per cycle. Uses rwsf_pkg.
`timescale 1ns / 1ps

module rwsf_grp_unit
    import rwsf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [CUMG_W-1:0] cumg,
    input  logic [TOT_W-1:0]  total,
    input  logic [GRP_W-1:0]  gm1,
    output grp_res_t          res
);

    logic              busy_reg, busy_next;
    logic [GRP_W-1:0]  k_reg, k_next;
    logic [CUMG_W-1:0] thr_reg, thr_next;
    logic [CUMG_W-1:0] cumg_reg, cumg_next;
    logic [TOT_W-1:0]  total_reg, total_next;
    logic [GRP_W-1:0]  gm1_reg, gm1_next;
    logic              step;

    assign step = (k_reg < gm1_reg) && (cumg_reg >= thr_reg);

    always_comb
    begin
        busy_next  = busy_reg;
        k_next     = k_reg;
        thr_next   = thr_reg;
        cumg_next  = cumg_reg;
        total_next = total_reg;
        gm1_next   = gm1_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            k_next     = '0;
            thr_next   = CUMG_W'(total);
            cumg_next  = cumg;
            total_next = total;
            gm1_next   = gm1;
        end
        else if (busy_reg)
        begin
            if (step)
            begin
                k_next   = k_reg + GRP_W'(1);
                thr_next = thr_reg + CUMG_W'(total_reg);
            end
            else
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else
            busy_reg <= busy_next;
    end

    always_ff @(posedge clk)
    begin
        k_reg     <= k_next;
        thr_reg   <= thr_next;
        cumg_reg  <= cumg_next;
        total_reg <= total_next;
        gm1_reg   <= gm1_next;
    end

    assign res.done = busy_reg && !step;
    assign res.grp  = k_reg;

endmodule

// File: rtl/rank_and_weighted_strata_filter.sv
// Loads write the memories when taken; a query reads the rank and group memories, then
// its result moves to the output register once free and is held there until taken.
// A last load ranks n = entry_count individuals: n scan passes over the single
// consumption/weight memory read port, plus a group search per nonzero-weight rank;
// in_ready is low throughout. Reset (async, active low) clears control, counts and
// config (num_groups 5, stratum 0); memories are not cleared.
`timescale 1ns / 1ps

module rank_and_weighted_strata_filter
    import rwsf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              op,
    input  logic [IDX_W-1:0]  index,
    input  logic [CONS_W-1:0] consumption,
    input  logic [WGT_W-1:0]  weight,
    input  logic              last,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [IDX_W-1:0]  queried,
    output logic              selected,
    output logic [GRP_W-1:0]  group_of_individual,
    output logic [IDX_W-1:0]  individual_at_rank,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_index,
    input  logic [NG_W-1:0]   cfg_data
);

    logic [CONS_W-1:0] cons_mem [DEPTH];
    logic [WGT_W-1:0]  wgt_mem  [DEPTH];
    logic [IDX_W-1:0]  rank_mem [DEPTH];
    logic [GRP_W:0]    grp_mem  [DEPTH];

    logic [CONS_W-1:0] cons_rd_reg;
    logic [WGT_W-1:0]  wgt_rd_reg;
    logic [IDX_W-1:0]  rank_rd_reg;
    logic [GRP_W:0]    grp_rd_reg;

    state_t            state_reg, state_next;
    logic [NG_W-1:0]   num_groups_reg;
    logic [GRP_W-1:0]  stratum_reg;
    logic [CNT_W-1:0]  entry_count_reg, entry_count_next;
    logic [CNT_W-1:0]  ranked_reg, ranked_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [CNT_W-1:0]  rank_reg, rank_next;
    logic [CNT_W-1:0]  addr_reg, addr_next;
    logic              rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0]  rd_idx_reg, rd_idx_next;
    logic              found_reg, found_next;
    logic              first_reg, first_next;
    logic [KEY_W-1:0]  best_key_reg, best_key_next;
    logic [WGT_W-1:0]  best_w_reg, best_w_next;
    logic [KEY_W-1:0]  bound_reg, bound_next;
    logic [TOT_W-1:0]  total_reg, total_next;
    logic [CUMG_W-1:0] cumg_reg, cumg_next;
    logic [NG_W-1:0]   g_run_reg, g_run_next;
    logic [IDX_W-1:0]  q_idx_reg, q_idx_next;
    logic              out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]  queried_reg, queried_next;
    logic              selected_reg, selected_next;
    logic [GRP_W-1:0]  grp_out_reg, grp_out_next;
    logic [IDX_W-1:0]  at_reg, at_next;

    logic              load_acc, query_acc, rd_issue;
    logic              rank_we, grp_we, grp_start;
    logic [GRP_W:0]    grp_wdata;
    logic [IDX_W-1:0]  best_idx;
    logic [KEY_W-1:0]  cand_key;
    logic [CNT_W-1:0]  idx_plus1, cnt_new;
    logic [NG_W-1:0]   g_q;
    logic              in_rank, grouped;
    logic [WGT_W+NG_W-1:0] wprod;
    grp_res_t          gres;

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign load_acc  = in_valid && in_ready && (op == OP_LOAD);
    assign query_acc = in_valid && in_ready && (op == OP_QUERY);
    assign rd_issue  = (state_reg == ST_SCAN) && (addr_reg < n_reg);
    assign best_idx  = ~best_key_reg[IDX_W-1:0];
    assign cand_key  = {cons_rd_reg, ~rd_idx_reg};
    assign idx_plus1 = {1'b0, index} + CNT_W'(1);
    assign cnt_new   = (idx_plus1 > entry_count_reg) ? idx_plus1 : entry_count_reg;
    assign wprod     = best_w_reg * g_run_reg;
    assign g_q       = eff_groups(num_groups_reg);
    assign in_rank   = ({1'b0, q_idx_reg} < ranked_reg);
    assign grouped   = in_rank && grp_rd_reg[GRP_W];

    rwsf_grp_unit u_grp
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (grp_start),
        .cumg  (cumg_reg),
        .total (total_reg),
        .gm1   (GRP_W'(g_run_reg - NG_W'(1))),
        .res   (gres)
    );

    always_comb
    begin
        state_next       = state_reg;
        entry_count_next = entry_count_reg;
        ranked_next      = ranked_reg;
        n_next           = n_reg;
        rank_next        = rank_reg;
        addr_next        = addr_reg;
        rd_vld_next      = rd_issue;
        rd_idx_next      = addr_reg[IDX_W-1:0];
        found_next       = found_reg;
        first_next       = first_reg;
        best_key_next    = best_key_reg;
        best_w_next      = best_w_reg;
        bound_next       = bound_reg;
        total_next       = total_reg;
        cumg_next        = cumg_reg;
        g_run_next       = g_run_reg;
        q_idx_next       = q_idx_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        queried_next     = queried_reg;
        selected_next    = selected_reg;
        grp_out_next     = grp_out_reg;
        at_next          = at_reg;
        rank_we          = 1'b0;
        grp_we           = 1'b0;
        grp_wdata        = '0;
        grp_start        = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (load_acc)
                begin
                    entry_count_next = cnt_new;
                    if (last)
                    begin
                        n_next     = cnt_new;
                        rank_next  = '0;
                        addr_next  = '0;
                        found_next = 1'b0;
                        first_next = 1'b1;
                        total_next = '0;
                        cumg_next  = '0;
                        g_run_next = eff_groups(num_groups_reg);
                        state_next = ST_SCAN;
                    end
                end
                else if (query_acc)
                begin
                    q_idx_next = index;
                    state_next = ST_QOUT;
                end
            end
            ST_QOUT:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    queried_next   = q_idx_reg;
                    grp_out_next   = grouped ? grp_rd_reg[GRP_W-1:0] : '0;
                    selected_next  = grouped && ({1'b0, stratum_reg} < g_q) &&
                        ({1'b0, grp_rd_reg[GRP_W-1:0]} ==
                         (g_q - NG_W'(1) - {1'b0, stratum_reg}));
                    at_next        = in_rank ? rank_rd_reg : '0;
                    state_next     = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                if (rd_issue)
                    addr_next = addr_reg + CNT_W'(1);
                if (rd_vld_reg)
                begin
                    if (first_reg)
                        total_next = total_reg + TOT_W'(wgt_rd_reg);
                    // pick the largest key below the previous winner
                    if ((first_reg || cand_key < bound_reg) &&
                        (!found_reg || cand_key > best_key_reg))
                    begin
                        best_key_next = cand_key;
                        best_w_next   = wgt_rd_reg;
                        found_next    = 1'b1;
                    end
                end
                if (!rd_issue && !rd_vld_reg)
                    state_next = ST_PASS_END;
            end
            ST_PASS_END:
            begin
                rank_we    = 1'b1;
                bound_next = best_key_reg;
                first_next = 1'b0;
                if (total_reg == '0 || best_w_reg == '0)
                begin
                    grp_we = 1'b1;
                    if (rank_reg + CNT_W'(1) == n_reg)
                    begin
                        ranked_next = n_reg;
                        state_next  = ST_IDLE;
                    end
                    else
                    begin
                        rank_next  = rank_reg + CNT_W'(1);
                        addr_next  = '0;
                        found_next = 1'b0;
                        state_next = ST_SCAN;
                    end
                end
                else
                begin
                    grp_start  = 1'b1;
                    state_next = ST_GRP_WAIT;
                end
            end
            ST_GRP_WAIT:
            begin
                if (gres.done)
                begin
                    grp_we    = 1'b1;
                    grp_wdata = {1'b1, gres.grp};
                    cumg_next = cumg_reg + CUMG_W'(wprod);
                    if (rank_reg + CNT_W'(1) == n_reg)
                    begin
                        ranked_next = n_reg;
                        state_next  = ST_IDLE;
                    end
                    else
                    begin
                        rank_next  = rank_reg + CNT_W'(1);
                        addr_next  = '0;
                        found_next = 1'b0;
                        state_next = ST_SCAN;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            num_groups_reg  <= NG_W'(5);
            stratum_reg     <= '0;
            entry_count_reg <= '0;
            ranked_reg      <= '0;
            rd_vld_reg      <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            entry_count_reg <= entry_count_next;
            ranked_reg      <= ranked_next;
            rd_vld_reg      <= rd_vld_next;
            out_valid_reg   <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_NUM_GROUPS: num_groups_reg <= cfg_data;
                    REG_STRATUM:    stratum_reg    <= cfg_data[GRP_W-1:0];
                    default:        num_groups_reg <= num_groups_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg        <= n_next;
        rank_reg     <= rank_next;
        addr_reg     <= addr_next;
        rd_idx_reg   <= rd_idx_next;
        found_reg    <= found_next;
        first_reg    <= first_next;
        best_key_reg <= best_key_next;
        best_w_reg   <= best_w_next;
        bound_reg    <= bound_next;
        total_reg    <= total_next;
        cumg_reg     <= cumg_next;
        g_run_reg    <= g_run_next;
        q_idx_reg    <= q_idx_next;
        queried_reg  <= queried_next;
        selected_reg <= selected_next;
        grp_out_reg  <= grp_out_next;
        at_reg       <= at_next;
    end

    always_ff @(posedge clk)
    begin
        if (load_acc)
        begin
            cons_mem[index] <= consumption;
            wgt_mem[index]  <= weight;
        end
        if (rd_issue)
        begin
            cons_rd_reg <= cons_mem[addr_reg[IDX_W-1:0]];
            wgt_rd_reg  <= wgt_mem[addr_reg[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rank_we)
            rank_mem[rank_reg[IDX_W-1:0]] <= best_idx;
        if (grp_we)
            grp_mem[best_idx] <= grp_wdata;
        // hold the query read while the result waits for the output register
        if (query_acc)
        begin
            rank_rd_reg <= rank_mem[index];
            grp_rd_reg  <= grp_mem[index];
        end
    end

    assign out_valid           = out_valid_reg;
    assign queried             = queried_reg;
    assign selected            = selected_reg;
    assign group_of_individual = grp_out_reg;
    assign individual_at_rank  = at_reg;

endmodule

// File: rtl/rwsf_checker.sv
// Port-level checks for rank_and_weighted_strata_filter, bound to the top level.
// Uses rwsf_pkg for the op codes.
`timescale 1ns / 1ps

module rwsf_checker
    import rwsf_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             op,
    input logic             last,
    input logic             out_valid,
    input logic             out_ready,
    input logic [IDX_W-1:0] queried
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(queried))
        else $error("result beat dropped or changed while stalled");

    a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && op == OP_LOAD |=> !$rose(out_valid))
        else $error("load beat produced a result");

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && op == OP_QUERY |=> !in_ready)
        else $error("input taken while query result pending");

    a_rank_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && op == OP_LOAD && last |=> !in_ready)
        else $error("input taken during ranking");

endmodule

bind rank_and_weighted_strata_filter rwsf_checker u_rwsf_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .last      (last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .queried   (queried)
);

// File: dv/rank_and_weighted_strata_filter_chk.sv
// Checker for the rank and weighted strata filter: watches the load/query,
// result and register channels, predicts every query result and compares.
// Depends on rwsf_pkg for widths and codes.
`timescale 1ns / 1ps

module rank_and_weighted_strata_filter_chk
    import rwsf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic              op,
    input  logic [IDX_W-1:0]  index,
    input  logic [CONS_W-1:0] consumption,
    input  logic [WGT_W-1:0]  weight,
    input  logic              last,
    input  logic              out_valid,
    input  logic              out_ready,
    input  logic [IDX_W-1:0]  queried,
    input  logic              selected,
    input  logic [GRP_W-1:0]  group_of_individual,
    input  logic [IDX_W-1:0]  individual_at_rank,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic              cfg_index,
    input  logic [NG_W-1:0]   cfg_data,
    output int                errors,
    output int                outstanding
);

    typedef struct {
        logic [IDX_W-1:0] idx;
        logic             sel;
        logic [GRP_W-1:0] grp;
        logic [IDX_W-1:0] at;
    } strata_answer_t;

    strata_answer_t   answers_due[$];

    logic [CONS_W-1:0] cons_mem [DEPTH];
    logic [WGT_W-1:0]  wgt_mem  [DEPTH];
    logic [IDX_W-1:0]  rank_mem [DEPTH];
    logic [GRP_W-1:0]  grp_mem  [DEPTH];
    bit                has_grp  [DEPTH];
    int                loaded_count;
    int                ranked_count;
    logic [NG_W-1:0]   ng_reg;
    logic [GRP_W-1:0]  st_reg;

    function automatic int groups_in_force();
        if (ng_reg == 0)
            return 1;
        if (ng_reg > MAX_GROUPS)
            return MAX_GROUPS;
        return int'(ng_reg);
    endfunction

    task automatic rank_population();
        bit               taken [DEPTH];
        longint unsigned  total;
        longint unsigned  cum;
        longint unsigned  g;
        longint unsigned  grp;
        int               best;
        bit               found;
        int               who;
        total = 0;
        cum = 0;
        g = groups_in_force();
        for (int c = 0; c < loaded_count; c++)
        begin
            taken[c] = 0;
            has_grp[c] = 0;
            total += wgt_mem[c];
        end
        for (int r = 0; r < loaded_count; r++)
        begin
            best = 0;
            found = 0;
            for (int c = 0; c < loaded_count; c++)
            begin
                if (!taken[c] && (!found || cons_mem[c] > cons_mem[best]))
                begin
                    best = c;
                    found = 1;
                end
            end
            taken[best] = 1;
            rank_mem[r] = IDX_W'(best);
        end
        ranked_count = loaded_count;
        if (total != 0)
        begin
            for (int r = 0; r < loaded_count; r++)
            begin
                who = rank_mem[r];
                if (wgt_mem[who] != 0)
                begin
                    grp = (cum * g) / total;
                    if (grp > g - 1)
                        grp = g - 1;
                    grp_mem[who] = GRP_W'(grp);
                    has_grp[who] = 1;
                    cum += wgt_mem[who];
                end
            end
        end
    endtask

    assign outstanding = answers_due.size();

    always @(posedge clk or negedge rst_n)
    begin
        strata_answer_t a;
        int g;
        if (!rst_n)
        begin
            answers_due.delete();
            loaded_count = 0;
            ranked_count = 0;
            ng_reg = NG_W'(5);
            st_reg = '0;
            errors = 0;
            for (int i = 0; i < DEPTH; i++)
                has_grp[i] = 0;
        end
        else
        begin
            // compare the result beat first; a query accepted now answers later
            if (out_valid && out_ready)
            begin
                if (answers_due.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result beat queried=%0d", $time, queried);
                end
                else
                begin
                    a = answers_due.pop_front();
                    if (queried !== a.idx)
                    begin
                        errors++;
                        $display("%0t: queried expected %0d actual %0d", $time, a.idx, queried);
                    end
                    if (selected !== a.sel)
                    begin
                        errors++;
                        $display("%0t: selected expected %0d actual %0d (idx %0d)",
                                 $time, a.sel, selected, a.idx);
                    end
                    if (group_of_individual !== a.grp)
                    begin
                        errors++;
                        $display("%0t: group expected %0d actual %0d (idx %0d)",
                                 $time, a.grp, group_of_individual, a.idx);
                    end
                    if (individual_at_rank !== a.at)
                    begin
                        errors++;
                        $display("%0t: individual_at_rank expected %0d actual %0d (idx %0d)",
                                 $time, a.at, individual_at_rank, a.idx);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_NUM_GROUPS)
                    ng_reg = cfg_data;
                else
                    st_reg = cfg_data[GRP_W-1:0];
            end
            if (in_valid && in_ready)
            begin
                if (op == OP_LOAD)
                begin
                    cons_mem[index] = consumption;
                    wgt_mem[index] = weight;
                    if (int'(index) + 1 > loaded_count)
                        loaded_count = int'(index) + 1;
                    if (last)
                        rank_population();
                end
                else
                begin
                    a.idx = index;
                    a.sel = 0;
                    a.grp = '0;
                    a.at = '0;
                    if (has_grp[index])
                    begin
                        g = groups_in_force();
                        a.grp = grp_mem[index];
                        if (int'(st_reg) < g && int'(grp_mem[index]) == g - 1 - int'(st_reg))
                            a.sel = 1;
                    end
                    if (int'(index) < ranked_count)
                        a.at = rank_mem[index];
                    answers_due.push_back(a);
                end
            end
        end
    end

endmodule

// File: dv/rank_and_weighted_strata_filter_tb.sv
// Top of the rank and weighted strata filter testbench: clock, reset, stimulus
// and verdict. Depends on rwsf_pkg, the block and rank_and_weighted_strata_filter_chk.
`timescale 1ns / 1ps

module rank_and_weighted_strata_filter_tb;
    import rwsf_pkg::*;

    localparam int POP_MAX = 48;
    localparam int ITEM_TARGET = 580;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic              op;
    logic [IDX_W-1:0]  index;
    logic [CONS_W-1:0] consumption;
    logic [WGT_W-1:0]  weight;
    logic              last;
    logic              out_valid;
    logic              out_ready;
    logic [IDX_W-1:0]  queried;
    logic              selected;
    logic [GRP_W-1:0]  group_of_individual;
    logic [IDX_W-1:0]  individual_at_rank;
    logic              cfg_valid;
    logic              cfg_ready;
    logic              cfg_index;
    logic [NG_W-1:0]   cfg_data;
    int                errors;
    int                outstanding;

    bit                quiet;
    bit                hold_req;
    bit                squeezed;
    int                items_sent;
    int                pop_hi;

    rank_and_weighted_strata_filter uut (.*);
    rank_and_weighted_strata_filter_chk chk (.*);

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    initial
    begin
        #5ms;
        $display("*** FAILED ***");
        $finish;
    end

    // receiver: random stalls, one long hold-off on request
    initial
    begin
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (400) @(posedge clk);
                hold_req = 0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    task automatic send_beat(logic o, int idx, logic [CONS_W-1:0] c,
                             logic [WGT_W-1:0] w, logic l);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= o;
        index <= IDX_W'(idx);
        consumption <= c;
        weight <= w;
        last <= l;
        do @(posedge clk); while (!in_ready);
        items_sent++;
    endtask

    // write only while the block is idle and no result is pending
    task automatic write_reg(logic ri, logic [NG_W-1:0] val);
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0 || !in_ready);
        cfg_valid <= 1'b1;
        cfg_index <= ri;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [CONS_W-1:0] pick_consumption();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            1: return CONS_W'($urandom_range(0, 3) * 100);
            default: return CONS_W'($urandom);
        endcase
    endfunction

    function automatic logic [WGT_W-1:0] pick_weight(bit all_zero);
        if (all_zero)
            return '0;
        case ($urandom_range(0, 5))
            0: return '0;
            1: return 24'hFFFFFF;
            2: return WGT_W'($urandom_range(1, 15));
            default: return WGT_W'($urandom);
        endcase
    endfunction

    // load a population (every index below the new top written), rank it, then query
    task automatic run_set(int new_hi, int n_reload, int n_query, bit all_zero, bit squeeze);
        int order[$];
        int qi;
        if (all_zero)
            for (int i = 0; i < new_hi; i++) order.push_back(i);
        else
        begin
            for (int i = pop_hi; i < new_hi; i++) order.push_back(i);
            for (int i = 0; i < n_reload && new_hi > 0; i++)
                order.push_back($urandom_range(0, new_hi - 1));
        end
        if (order.size() == 0)
            order.push_back(0);
        order.shuffle();
        if (new_hi > pop_hi)
            pop_hi = new_hi;
        foreach (order[i])
            send_beat(OP_LOAD, order[i], pick_consumption(), pick_weight(all_zero),
                      i == order.size() - 1);
        if (squeeze)
        begin
            hold_req = 1;
            squeezed = 1;
        end
        for (int i = 0; i < n_query; i++)
        begin
            if ($urandom_range(0, 9) < 7)
                qi = $urandom_range(0, (pop_hi + 2 > 1023) ? 1023 : pop_hi + 2);
            else
                qi = $urandom_range(0, 1023);
            send_beat(OP_QUERY, qi, CONS_W'($urandom), WGT_W'($urandom),
                      1'($urandom_range(0, 1)));
        end
        in_valid <= 1'b0;
    endtask

    task automatic pick_config();
        logic [NG_W-1:0] ng;
        case ($urandom_range(0, 5))
            0: ng = 5'd0;
            1: ng = 5'd1;
            2: ng = 5'd16;
            3: ng = NG_W'($urandom_range(17, 31));
            default: ng = NG_W'($urandom_range(1, 16));
        endcase
        write_reg(REG_NUM_GROUPS, ng);
        write_reg(REG_STRATUM, NG_W'($urandom));
    endtask

    initial
    begin
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        op <= OP_LOAD;
        index <= '0;
        consumption <= '0;
        weight <= '0;
        last <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_NUM_GROUPS;
        cfg_data <= '0;
        quiet = 0;
        hold_req = 0;
        squeezed = 0;
        items_sent = 0;
        pop_hi = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // queries before any ranking
        send_beat(OP_QUERY, 0, '0, '0, 1'b0);
        send_beat(OP_QUERY, 1023, 16'hFFFF, 24'hFFFFFF, 1'b1);
        // extremes, ties and zero weights under reset settings
        send_beat(OP_LOAD, 0, 16'hFFFF, 24'hFFFFFF, 1'b0);
        send_beat(OP_LOAD, 1, 16'h0000, 24'h000000, 1'b0);
        send_beat(OP_LOAD, 2, 16'hFFFF, 24'h000001, 1'b0);
        send_beat(OP_LOAD, 3, 16'h0000, 24'hFFFFFF, 1'b1);
        for (int i = 0; i < 5; i++)
            send_beat(OP_QUERY, i, '0, '0, 1'b0);
        send_beat(OP_QUERY, 1023, '0, '0, 1'b0);
        in_valid <= 1'b0;
        // zero groups, stratum beyond the group count
        write_reg(REG_NUM_GROUPS, 5'd0);
        write_reg(REG_STRATUM, 5'd15);
        run_set(6, 2, 4, 0, 0);
        write_reg(REG_NUM_GROUPS, 5'd31);
        write_reg(REG_STRATUM, 5'd0);
        run_set(6, 0, 4, 1, 0);
        write_reg(REG_NUM_GROUPS, 5'd16);
        write_reg(REG_STRATUM, 5'd31);
        run_set(8, 3, 4, 0, 0);

        while (items_sent < ITEM_TARGET)
        begin
            if (items_sent > ITEM_TARGET * 85 / 100)
                quiet = 1;
            pick_config();
            run_set((pop_hi + 6 > POP_MAX) ? POP_MAX : pop_hi + $urandom_range(0, 6),
                    $urandom_range(1, 8), $urandom_range(4, 16),
                    $urandom_range(0, 11) == 0, !squeezed && items_sent > 200);
        end

        wait (outstanding == 0);
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
